@@ design/mps_pkg.sv @@
// ----------------------------------------------------------------------------
// mps_pkg
// Shared types and codes for the motion program sequencer: request and
// response payloads, controller command and status groups, field codes.
// ----------------------------------------------------------------------------
package mps_pkg;

   localparam int MAX_MOVES = 16;
   localparam int SLOT_W    = $clog2(MAX_MOVES);
   localparam int COUNT_W   = 5;

   // request kinds
   localparam logic CMD_BUTTON  = 1'b0;
   localparam logic CMD_SERVICE = 1'b1;

   // button codes
   localparam logic [2:0] BTN_FWD    = 3'd0;
   localparam logic [2:0] BTN_BACK   = 3'd1;
   localparam logic [2:0] BTN_TURN_L = 3'd2;
   localparam logic [2:0] BTN_TURN_R = 3'd3;
   localparam logic [2:0] BTN_GO     = 3'd4;
   localparam logic [2:0] BTN_PAUSE  = 3'd5;
   localparam logic [2:0] BTN_CLEAR  = 3'd6;

   // drive codes
   localparam logic [2:0] OP_STOP     = 3'd0;
   localparam logic [2:0] OP_FWD      = 3'd1;
   localparam logic [2:0] OP_BACKWARD = 3'd2;
   localparam logic [2:0] OP_LEFT     = 3'd3;
   localparam logic [2:0] OP_RIGHT    = 3'd4;

   // light codes
   localparam logic [1:0] LT_NONE   = 2'd0;
   localparam logic [1:0] LT_BLACK  = 2'd1;
   localparam logic [1:0] LT_WHITE  = 2'd2;
   localparam logic [1:0] LT_YELLOW = 2'd3;

   // event codes
   localparam logic [3:0] EV_NONE     = 4'd0;
   localparam logic [3:0] EV_ADDED    = 4'd1;
   localparam logic [3:0] EV_FULL     = 4'd2;
   localparam logic [3:0] EV_EMPTY_GO = 4'd3;
   localparam logic [3:0] EV_ARMED    = 4'd4;
   localparam logic [3:0] EV_FIRST    = 4'd5;
   localparam logic [3:0] EV_NEXT     = 4'd6;
   localparam logic [3:0] EV_GAP      = 4'd7;
   localparam logic [3:0] EV_DONE     = 4'd8;
   localparam logic [3:0] EV_PAUSED   = 4'd9;
   localparam logic [3:0] EV_CLEARED  = 4'd10;

   // run state codes as reported
   localparam logic [2:0] RUN_IDLE    = 3'd0;
   localparam logic [2:0] RUN_ARMED   = 3'd1;
   localparam logic [2:0] RUN_RUNNING = 3'd2;
   localparam logic [2:0] RUN_GAP     = 3'd3;
   localparam logic [2:0] RUN_PAUSED  = 3'd4;

   // register indexes
   localparam logic [2:0] CSR_ARM_DELAY  = 3'd0;
   localparam logic [2:0] CSR_GAP        = 3'd1;
   localparam logic [2:0] CSR_STEPS_FWD  = 3'd2;
   localparam logic [2:0] CSR_STEPS_BACK = 3'd3;
   localparam logic [2:0] CSR_STEPS_LEFT = 3'd4;
   localparam logic [2:0] CSR_STEPS_RIGHT = 3'd5;
   localparam logic [2:0] CSR_FLASH      = 3'd6;

   typedef struct packed {
      logic               command;
      logic [2:0]         button;
      logic [31:0]        now_ms;
      logic signed [31:0] executed_steps;
      logic               button_mode;
      logic               calibrating;
   } req_type;

   typedef struct packed {
      logic [2:0] motor_op;
      logic       motor_issue;
      logic       odometer_reset;
      logic [1:0] light_color;
      logic [3:0] event_code;
      logic [2:0] run_state;
      logic [4:0] program_length;
      logic [3:0] current_index;
   } rsp_type;

   typedef enum logic [1:0] {
      DRIVE_KEEP,
      DRIVE_STOP,
      DRIVE_CURRENT
   } drive_sel_type;

   typedef struct packed {
      logic          add_move;
      logic          clear_prog;
      logic          zero_index;
      logic          inc_index;
      logic          arm_capture;
      logic          gap_capture;
      drive_sel_type drive_sel;
      logic          odometer_reset;
      logic [1:0]    light_color;
      logic [3:0]    event_code;
      logic [2:0]    run_state;
   } ctrl_cmd_type;

   typedef struct packed {
      logic accept;
      logic prog_full;
      logic prog_empty;
      logic arm_done;
      logic gap_done;
      logic in_flash;
      logic target_reached;
      logic last_move;
   } dp_status_type;

endpackage

@@ design/mps_ctrl.sv @@
// ----------------------------------------------------------------------------
// mps_ctrl
// Phase state machine: decodes each request against the current phase and
// the datapath status, and issues the datapath commands for that request.
// ----------------------------------------------------------------------------
module mps_ctrl
   import mps_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_payload,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_ARMED   = 5'b00010,
      PH_RUNNING = 5'b00100,
      PH_GAP     = 5'b01000,
      PH_PAUSED  = 5'b10000
   } phase_type;

   phase_type phase_ff;
   phase_type phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (status.accept) begin
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      cmd = '0;
      cmd.drive_sel = DRIVE_KEEP;
      cmd.light_color = LT_NONE;
      cmd.event_code = EV_NONE;
      if (req_payload.command == CMD_BUTTON) begin
         case (req_payload.button)
            BTN_FWD, BTN_BACK, BTN_TURN_L, BTN_TURN_R: begin
               if (status.prog_full) begin
                  cmd.event_code = EV_FULL;
               end else begin
                  cmd.add_move = 1'b1;
                  cmd.event_code = EV_ADDED;
               end
            end
            BTN_GO: begin
               if (status.prog_empty) begin
                  cmd.event_code = EV_EMPTY_GO;
               end else begin
                  cmd.zero_index = 1'b1;
                  cmd.arm_capture = 1'b1;
                  phase_in = PH_ARMED;
                  cmd.event_code = EV_ARMED;
               end
            end
            BTN_PAUSE: begin
               phase_in = PH_PAUSED;
               cmd.drive_sel = DRIVE_STOP;
               cmd.event_code = EV_PAUSED;
            end
            BTN_CLEAR: begin
               cmd.clear_prog = 1'b1;
               cmd.zero_index = 1'b1;
               phase_in = PH_IDLE;
               cmd.drive_sel = DRIVE_STOP;
               cmd.event_code = EV_CLEARED;
            end
            default: begin
            end
         endcase
      end else if (!req_payload.button_mode || req_payload.calibrating) begin
         phase_in = PH_PAUSED;
         cmd.drive_sel = DRIVE_STOP;
         cmd.event_code = EV_PAUSED;
      end else begin
         case (phase_ff)
            PH_ARMED: begin
               if (status.arm_done) begin
                  cmd.odometer_reset = 1'b1;
                  cmd.drive_sel = DRIVE_CURRENT;
                  phase_in = PH_RUNNING;
                  cmd.event_code = EV_FIRST;
               end else begin
                  cmd.drive_sel = DRIVE_STOP;
                  cmd.light_color = LT_BLACK;
               end
            end
            PH_RUNNING: begin
               if (status.target_reached) begin
                  cmd.drive_sel = DRIVE_STOP;
                  if (status.last_move) begin
                     phase_in = PH_IDLE;
                     cmd.light_color = LT_YELLOW;
                     cmd.event_code = EV_DONE;
                  end else begin
                     cmd.inc_index = 1'b1;
                     cmd.gap_capture = 1'b1;
                     phase_in = PH_GAP;
                     cmd.event_code = EV_GAP;
                  end
               end
            end
            PH_GAP: begin
               if (status.gap_done) begin
                  cmd.odometer_reset = 1'b1;
                  cmd.drive_sel = DRIVE_CURRENT;
                  phase_in = PH_RUNNING;
                  cmd.event_code = EV_NEXT;
               end else begin
                  cmd.drive_sel = DRIVE_STOP;
                  cmd.light_color = status.in_flash ? LT_WHITE : LT_BLACK;
               end
            end
            default: begin
               cmd.drive_sel = DRIVE_STOP;
            end
         endcase
      end

      case (phase_in)
         PH_ARMED:   cmd.run_state = RUN_ARMED;
         PH_RUNNING: cmd.run_state = RUN_RUNNING;
         PH_GAP:     cmd.run_state = RUN_GAP;
         PH_PAUSED:  cmd.run_state = RUN_PAUSED;
         default:    cmd.run_state = RUN_IDLE;
      endcase
   end

endmodule

@@ design/mps_datapath.sv @@
// ----------------------------------------------------------------------------
// mps_datapath
// Configuration registers, move program store, counters, timestamps, drive
// latch, elapsed-time and step compares, and the response register.
// ----------------------------------------------------------------------------
module mps_datapath
   import mps_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_payload,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_payload,
   input  logic          csr_write_en,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_wdata,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status
);

   logic [15:0] arm_delay_ff;
   logic [15:0] gap_ms_ff;
   logic [31:0] steps_fwd_ff;
   logic [31:0] steps_back_ff;
   logic [31:0] steps_left_ff;
   logic [31:0] steps_right_ff;
   logic [15:0] flash_ff;

   logic [2:0]  move_ops_ff [MAX_MOVES];
   logic [31:0] move_targets_ff [MAX_MOVES];
   logic [2:0]  cur_op_ff;
   logic [31:0] cur_target_ff;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [SLOT_W-1:0]  index_ff;
   logic [SLOT_W-1:0]  index_in;
   logic [31:0]        arm_start_ff;
   logic [31:0]        gap_start_ff;
   logic [2:0]         drive_ff;
   logic [2:0]         drive_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   logic               accept;
   logic [2:0]         new_op;
   logic [31:0]        new_target;
   logic [31:0]        arm_elapsed;
   logic [31:0]        gap_elapsed;
   logic [31:0]        step_mag;
   logic [COUNT_W-1:0] next_slot;

   assign req_stall   = rsp_valid_ff && rsp_stall;
   assign accept      = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // compares for the controller
   assign arm_elapsed = req_payload.now_ms - arm_start_ff;
   assign gap_elapsed = req_payload.now_ms - gap_start_ff;
   assign step_mag    = req_payload.executed_steps[31] ?
                        (32'd0 - $unsigned(req_payload.executed_steps)) :
                        $unsigned(req_payload.executed_steps);
   assign next_slot   = {1'b0, index_ff} + COUNT_W'(1);

   always_comb begin
      status.accept         = accept;
      status.prog_full      = count_ff >= COUNT_W'(MAX_MOVES);
      status.prog_empty     = count_ff == '0;
      status.arm_done       = arm_elapsed >= {16'd0, arm_delay_ff};
      status.gap_done       = gap_elapsed >= {16'd0, gap_ms_ff};
      status.in_flash       = gap_elapsed <= {16'd0, flash_ff};
      status.target_reached = step_mag >= cur_target_ff;
      status.last_move      = next_slot >= count_ff;
   end

   // op and target of a move button
   always_comb begin
      case (req_payload.button)
         BTN_FWD: begin
            new_op = OP_FWD;
            new_target = steps_fwd_ff;
         end
         BTN_BACK: begin
            new_op = OP_BACKWARD;
            new_target = steps_back_ff;
         end
         BTN_TURN_L: begin
            new_op = OP_LEFT;
            new_target = steps_left_ff;
         end
         default: begin
            new_op = OP_RIGHT;
            new_target = steps_right_ff;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear_prog) begin
         count_in = '0;
      end else if (cmd.add_move) begin
         count_in = count_ff + COUNT_W'(1);
      end
      index_in = index_ff;
      if (cmd.zero_index) begin
         index_in = '0;
      end else if (cmd.inc_index) begin
         index_in = index_ff + SLOT_W'(1);
      end
      case (cmd.drive_sel)
         DRIVE_STOP:    drive_in = OP_STOP;
         DRIVE_CURRENT: drive_in = cur_op_ff;
         default:       drive_in = drive_ff;
      endcase
      rsp_in.motor_op       = drive_in;
      rsp_in.motor_issue    = drive_in != drive_ff;
      rsp_in.odometer_reset = cmd.odometer_reset;
      rsp_in.light_color    = cmd.light_color;
      rsp_in.event_code     = cmd.event_code;
      rsp_in.run_state      = cmd.run_state;
      rsp_in.program_length = count_in;
      rsp_in.current_index  = index_in;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_delay_ff   <= 16'd1000;
         gap_ms_ff      <= 16'd1000;
         steps_fwd_ff   <= 32'd1000;
         steps_back_ff  <= 32'd1000;
         steps_left_ff  <= 32'd500;
         steps_right_ff <= 32'd500;
         flash_ff       <= 16'd500;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ARM_DELAY:   arm_delay_ff   <= csr_wdata[15:0];
            CSR_GAP:         gap_ms_ff      <= csr_wdata[15:0];
            CSR_STEPS_FWD:   steps_fwd_ff   <= csr_wdata;
            CSR_STEPS_BACK:  steps_back_ff  <= csr_wdata;
            CSR_STEPS_LEFT:  steps_left_ff  <= csr_wdata;
            CSR_STEPS_RIGHT: steps_right_ff <= csr_wdata;
            CSR_FLASH:       flash_ff       <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         index_ff     <= '0;
         arm_start_ff <= '0;
         gap_start_ff <= '0;
         drive_ff     <= OP_STOP;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
            index_ff <= index_in;
            drive_ff <= drive_in;
            if (cmd.arm_capture) begin
               arm_start_ff <= req_payload.now_ms;
            end
            if (cmd.gap_capture) begin
               gap_start_ff <= req_payload.now_ms;
            end
         end
      end
   end

   // program store, with the entry at the next play index read ahead
   always_ff @(posedge clock) begin
      if (accept && cmd.add_move) begin
         move_ops_ff[count_ff[SLOT_W-1:0]]     <= new_op;
         move_targets_ff[count_ff[SLOT_W-1:0]] <= new_target;
      end
      if (accept) begin
         if (cmd.add_move && count_ff[SLOT_W-1:0] == index_in) begin
            cur_op_ff     <= new_op;
            cur_target_ff <= new_target;
         end else begin
            cur_op_ff     <= move_ops_ff[index_in];
            cur_target_ff <= move_targets_ff[index_in];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

@@ design/motion_program_sequencer.sv @@
// ----------------------------------------------------------------------------
// motion_program_sequencer
// Builds a bounded program of motion moves from button requests and plays it
// back on service requests: arm delay, move until step target, gap, done.
// ----------------------------------------------------------------------------
//  port group   direction  handshake          payload
//  req_*        in         req_valid/stall    req_type
//  rsp_*        out        rsp_valid/stall    rsp_type
//  csr_*        in         csr_write_en       csr_index, csr_wdata
//
//  one request per cycle while req_stall is low; its response is registered and shows the next cycle
//  the response register is the only stage, so a request is taken while the
//  previous response is being taken in the same cycle
//  req_stall is high only while a response waits under rsp_stall
//  synchronous reset; no clearing pass, the program store is not reset
// ----------------------------------------------------------------------------
module motion_program_sequencer
   import mps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   mps_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .status      (status),
      .cmd         (cmd)
   );

   mps_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .status       (status)
   );

endmodule
